// ===== design/ecpsm_pkg.sv =====
// shared constants and types for the elliptic-curve scalar multiplier
`timescale 1ns / 1ps
`default_nettype none
package ecpsm_pkg;

  // default widths
  localparam int COORD_WIDTH_DEF  = 32;
  localparam int SCALAR_WIDTH_DEF = 64;

  // configuration register indexes and reset values
  localparam logic REG_FIELD_MODULUS = 1'b0;
  localparam logic REG_CURVE_COEFF_A = 1'b1;
  localparam logic [31:0] FIELD_MODULUS_RESET = 32'd223;
  localparam logic [31:0] CURVE_COEFF_A_RESET = 32'd0;

  // operations of the shared modular unit
  typedef logic op_t;
  localparam op_t OP_MUL = 1'b0;
  localparam op_t OP_DIV = 1'b1;

  // request to the shared unit
  typedef struct packed {
    logic start;
    op_t  op;
  } unit_ctrl_t;

  // status back from the shared unit
  typedef struct packed {
    logic done;
    logic busy;
  } unit_stat_t;

endpackage
`default_nettype wire

// ===== design/ecpsm_modunit.sv =====
// bit-serial shared unit: modular multiply or restoring divide, one bit per cycle
`timescale 1ns / 1ps
`default_nettype none
module ecpsm_modunit import ecpsm_pkg::*; #(
  parameter int W = COORD_WIDTH_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire unit_ctrl_t   ctrl,
  input  wire logic [W-1:0] opa,
  input  wire logic [W-1:0] opb,
  input  wire logic [W-1:0] modulus,
  output unit_stat_t        stat,
  output logic [W-1:0]      res,
  output logic [W-1:0]      quot
);

  localparam int CW = $clog2(W + 1);
  localparam logic [CW-1:0] LAST = CW'(W - 1);

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  op_t           op_r, op_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [W-1:0]  acc_r, acc_nxt;
  logic [W-1:0]  sh_r, sh_nxt;
  logic [W-1:0]  u_r, u_nxt;
  logic [W-1:0]  m_r, m_nxt;

  // one step of either operation
  logic [W:0] dbl, dbl_red, sum, sum_red, rem_try;
  logic       qbit;

  always_comb begin
    // multiply: acc = 2*acc + bit*u, reduced twice
    dbl     = {acc_r, 1'b0};
    dbl_red = (dbl >= {1'b0, m_r}) ? dbl - {1'b0, m_r} : dbl;
    sum     = dbl_red + (sh_r[W-1] ? {1'b0, u_r} : '0);
    sum_red = (sum >= {1'b0, m_r}) ? sum - {1'b0, m_r} : sum;
    // divide: shift in next dividend bit, trial subtract
    rem_try = {acc_r, sh_r[W-1]};
    qbit    = (rem_try >= {1'b0, m_r});
  end

  // sequencing of the unit
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    op_nxt   = op_r;
    cnt_nxt  = cnt_r;
    acc_nxt  = acc_r;
    sh_nxt   = sh_r;
    u_nxt    = u_r;
    m_nxt    = m_r;
    if (ctrl.start && !busy_r) begin
      busy_nxt = 1'b1;
      op_nxt   = ctrl.op;
      cnt_nxt  = '0;
      acc_nxt  = '0;
      u_nxt    = opa;
      sh_nxt   = (ctrl.op == OP_MUL) ? opb : opa;
      m_nxt    = (ctrl.op == OP_MUL) ? modulus : opb;
    end else if (busy_r) begin
      unique case (op_r)
        OP_MUL: begin
          acc_nxt = sum_red[W-1:0];
          sh_nxt  = {sh_r[W-2:0], 1'b0};
        end
        OP_DIV: begin
          acc_nxt = qbit ? W'(rem_try - {1'b0, m_r}) : rem_try[W-1:0];
          sh_nxt  = {sh_r[W-2:0], qbit};
        end
        default: begin
          acc_nxt = acc_r;
        end
      endcase
      cnt_nxt = cnt_r + CW'(1);
      if (cnt_r == LAST) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    op_r  <= op_nxt;
    cnt_r <= cnt_nxt;
    acc_r <= acc_nxt;
    sh_r  <= sh_nxt;
    u_r   <= u_nxt;
    m_r   <= m_nxt;
  end

  assign stat.done = done_r;
  assign stat.busy = busy_r;
  assign res       = acc_r;
  assign quot      = sh_r;

endmodule
`default_nettype wire

// ===== design/ec_point_scalar_multiply.sv =====
// elliptic-curve scalar multiplier, affine double-and-add with euclid inverse
//
//  channel   ports                                  handshake
//  request   start, in_scalar, in_point_*           accepted when start && !busy
//  result    out_valid, out_result_*                one-cycle strobe, no stall
//  config    psel, penable, pwrite, paddr, pwdata   apb write, pready tied high
//
// multiplies and divides run on one shared bit-serial unit; adds and subtracts are combinational
// an inverse takes up to about 1.5*COORD_WIDTH euclid rounds of a divide and a multiply
// busy stays high from accept until the result strobe; reset is synchronous, active low
// the result cannot be held off: it is presented for exactly one cycle
`timescale 1ns / 1ps
`default_nettype none
module ec_point_scalar_multiply import ecpsm_pkg::*; #(
  parameter int COORD_WIDTH  = COORD_WIDTH_DEF,
  parameter int SCALAR_WIDTH = SCALAR_WIDTH_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    start,
  output logic                         busy,
  input  wire logic [SCALAR_WIDTH-1:0] in_scalar,
  input  wire logic [COORD_WIDTH-1:0]  in_point_x,
  input  wire logic [COORD_WIDTH-1:0]  in_point_y,
  input  wire logic                    in_point_infinite,
  output logic                         out_valid,
  output logic [COORD_WIDTH-1:0]       out_result_x,
  output logic [COORD_WIDTH-1:0]       out_result_y,
  output logic                         out_result_infinite,
  input  wire logic                    psel,
  input  wire logic                    penable,
  input  wire logic                    pwrite,
  input  wire logic [2:0]              paddr,
  input  wire logic [31:0]             pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  localparam int W  = COORD_WIDTH;
  localparam int SW = SCALAR_WIDTH;

  // sequencer codes
  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_RX      = 4'd1;
  localparam logic [3:0] S_RY      = 4'd2;
  localparam logic [3:0] S_RA      = 4'd3;
  localparam logic [3:0] S_BIT     = 4'd4;
  localparam logic [3:0] S_RDBL    = 4'd5;
  localparam logic [3:0] S_SQ      = 4'd6;
  localparam logic [3:0] S_N3      = 4'd7;
  localparam logic [3:0] S_NA      = 4'd8;
  localparam logic [3:0] S_INV_CHK = 4'd9;
  localparam logic [3:0] S_INV_DIV = 4'd10;
  localparam logic [3:0] S_INV_MUL = 4'd11;
  localparam logic [3:0] S_LAM     = 4'd12;
  localparam logic [3:0] S_L2      = 4'd13;
  localparam logic [3:0] S_RYM     = 4'd14;
  localparam logic [3:0] S_OUT     = 4'd15;

  // modular add and subtract of values below p
  function automatic logic [W-1:0] modadd(input logic [W-1:0] a, input logic [W-1:0] b,
                                          input logic [W-1:0] m);
    logic [W:0] s;
    s = {1'b0, a} + {1'b0, b};
    modadd = (s >= {1'b0, m}) ? W'(s - {1'b0, m}) : s[W-1:0];
  endfunction

  function automatic logic [W-1:0] modsub(input logic [W-1:0] a, input logic [W-1:0] b,
                                          input logic [W-1:0] m);
    modsub = (a >= b) ? (a - b) : (a + (m - b));
  endfunction

  // configuration registers
  logic [31:0] field_modulus_r, curve_coeff_a_r;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      field_modulus_r <= FIELD_MODULUS_RESET;
      curve_coeff_a_r <= CURVE_COEFF_A_RESET;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_FIELD_MODULUS) field_modulus_r <= pwdata;
      if (paddr[2] == REG_CURVE_COEFF_A) curve_coeff_a_r <= pwdata;
    end
  end

  assign prdata = (paddr[2] == REG_CURVE_COEFF_A) ? curve_coeff_a_r : field_modulus_r;

  // sequencer and working registers
  logic [3:0]    state_r, state_nxt;
  logic          issued_r, issued_nxt;
  logic [SW-1:0] k_r, k_nxt;
  logic [W-1:0]  p_r, p_nxt, ca_r, ca_nxt;
  logic [W-1:0]  px_r, px_nxt, py_r, py_nxt;
  logic          pinf_r, pinf_nxt;
  logic [W-1:0]  ax_r, ax_nxt, ay_r, ay_nxt;
  logic          ainf_r, ainf_nxt;
  logic [W-1:0]  ux_r, ux_nxt, uy_r, uy_nxt, vx_r, vx_nxt;
  logic          dbl_r, dbl_nxt, tgt_acc_r, tgt_acc_nxt;
  logic [W-1:0]  num_r, num_nxt, t_r, t_nxt, lam_r, lam_nxt, rx_r, rx_nxt;
  logic [W-1:0]  r0_r, r0_nxt, r1_r, r1_nxt, s0_r, s0_nxt, s1_r, s1_nxt, q_r, q_nxt;

  // shared unit
  unit_ctrl_t   uctrl;
  unit_stat_t   ustat;
  logic [W-1:0] uopa, uopb, ures, uquot;
  logic         uses_unit;
  logic [W-1:0] q_red, ry_val;

  ecpsm_modunit #(.W(W)) u_modunit (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (uctrl),
    .opa     (uopa),
    .opb     (uopb),
    .modulus (p_r),
    .stat    (ustat),
    .res     (ures),
    .quot    (uquot)
  );

  // unit operand selection
  always_comb begin
    q_red     = (q_r >= p_r) ? (q_r - p_r) : q_r;
    uses_unit = 1'b1;
    uctrl.op  = OP_MUL;
    uopa      = '0;
    uopb      = '0;
    unique case (state_r)
      S_RX:      begin uctrl.op = OP_DIV; uopa = px_r;  uopb = p_r;  end
      S_RY:      begin uctrl.op = OP_DIV; uopa = py_r;  uopb = p_r;  end
      S_RA:      begin uctrl.op = OP_DIV; uopa = ca_r;  uopb = p_r;  end
      S_INV_DIV: begin uctrl.op = OP_DIV; uopa = r0_r;  uopb = r1_r; end
      S_SQ:      begin uopa = ux_r;  uopb = ux_r;  end
      S_INV_MUL: begin uopa = q_red; uopb = s1_r;  end
      S_LAM:     begin uopa = num_r; uopb = s0_r;  end
      S_L2:      begin uopa = lam_r; uopb = lam_r; end
      S_RYM:     begin uopa = lam_r; uopb = modsub(ux_r, rx_r, p_r); end
      default:   uses_unit = 1'b0;
    endcase
    uctrl.start = uses_unit && !issued_r && !ustat.busy;
  end

  // sequencer
  always_comb begin
    state_nxt   = state_r;
    issued_nxt  = issued_r;
    k_nxt       = k_r;
    p_nxt       = p_r;
    ca_nxt      = ca_r;
    px_nxt      = px_r;
    py_nxt      = py_r;
    pinf_nxt    = pinf_r;
    ax_nxt      = ax_r;
    ay_nxt      = ay_r;
    ainf_nxt    = ainf_r;
    ux_nxt      = ux_r;
    uy_nxt      = uy_r;
    vx_nxt      = vx_r;
    dbl_nxt     = dbl_r;
    tgt_acc_nxt = tgt_acc_r;
    num_nxt     = num_r;
    t_nxt       = t_r;
    lam_nxt     = lam_r;
    rx_nxt      = rx_r;
    r0_nxt      = r0_r;
    r1_nxt      = r1_r;
    s0_nxt      = s0_r;
    s1_nxt      = s1_r;
    q_nxt       = q_r;
    ry_val      = modsub(ures, uy_r, p_r);

    if (uctrl.start) issued_nxt = 1'b1;
    if (ustat.done)  issued_nxt = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          k_nxt    = in_scalar;
          px_nxt   = in_point_x;
          py_nxt   = in_point_y;
          pinf_nxt = in_point_infinite;
          ainf_nxt = 1'b1;
          p_nxt    = field_modulus_r[W-1:0];
          ca_nxt   = curve_coeff_a_r[W-1:0];
          state_nxt = (field_modulus_r[W-1:0] < W'(3)) ? S_OUT : S_RX;
        end
      end
      // reduce inputs and coefficient modulo p
      S_RX: if (ustat.done) begin px_nxt = ures; state_nxt = S_RY; end
      S_RY: if (ustat.done) begin py_nxt = ures; state_nxt = S_RA; end
      S_RA: if (ustat.done) begin ca_nxt = ures; state_nxt = S_BIT; end
      // next scalar bit: addition special cases
      S_BIT: begin
        if (k_r == '0) begin
          state_nxt = S_OUT;
        end else if (!k_r[0]) begin
          state_nxt = S_RDBL;
        end else if (ainf_r) begin
          ax_nxt = px_r; ay_nxt = py_r; ainf_nxt = pinf_r;
          state_nxt = S_RDBL;
        end else if (pinf_r) begin
          state_nxt = S_RDBL;
        end else if (ax_r == px_r && ay_r == py_r) begin
          if (ay_r == '0) begin
            ainf_nxt  = 1'b1;
            state_nxt = S_RDBL;
          end else begin
            ux_nxt = ax_r; uy_nxt = ay_r; dbl_nxt = 1'b1; tgt_acc_nxt = 1'b1;
            state_nxt = S_SQ;
          end
        end else if (ax_r == px_r) begin
          ainf_nxt  = 1'b1;
          state_nxt = S_RDBL;
        end else begin
          ux_nxt = ax_r; uy_nxt = ay_r; vx_nxt = px_r;
          dbl_nxt = 1'b0; tgt_acc_nxt = 1'b1;
          num_nxt = modsub(py_r, ay_r, p_r);
          r0_nxt  = modsub(px_r, ax_r, p_r);
          r1_nxt  = p_r;
          s0_nxt  = W'(1);
          s1_nxt  = '0;
          state_nxt = S_INV_CHK;
        end
      end
      // doubling of the running point
      S_RDBL: begin
        if (pinf_r || py_r == '0) begin
          pinf_nxt  = 1'b1;
          k_nxt     = k_r >> 1;
          state_nxt = S_BIT;
        end else begin
          ux_nxt = px_r; uy_nxt = py_r; dbl_nxt = 1'b1; tgt_acc_nxt = 1'b0;
          state_nxt = S_SQ;
        end
      end
      // doubling numerator 3x^2 + a and denominator 2y
      S_SQ: if (ustat.done) begin t_nxt = ures; state_nxt = S_N3; end
      S_N3: begin
        num_nxt   = modadd(t_r, t_r, p_r);
        state_nxt = S_NA;
      end
      S_NA: begin
        num_nxt   = modadd(modadd(num_r, t_r, p_r), ca_r, p_r);
        r0_nxt    = modadd(uy_r, uy_r, p_r);
        r1_nxt    = p_r;
        s0_nxt    = W'(1);
        s1_nxt    = '0;
        state_nxt = S_INV_CHK;
      end
      // extended euclid rounds
      S_INV_CHK: state_nxt = (r1_r == '0) ? S_LAM : S_INV_DIV;
      S_INV_DIV: if (ustat.done) begin
        q_nxt = uquot; t_nxt = ures; state_nxt = S_INV_MUL;
      end
      S_INV_MUL: if (ustat.done) begin
        r0_nxt = r1_r; r1_nxt = t_r;
        s0_nxt = s1_r; s1_nxt = modsub(s0_r, ures, p_r);
        state_nxt = S_INV_CHK;
      end
      // slope and new coordinates
      S_LAM: if (ustat.done) begin lam_nxt = ures; state_nxt = S_L2; end
      S_L2: if (ustat.done) begin
        rx_nxt    = modsub(modsub(ures, ux_r, p_r), dbl_r ? ux_r : vx_r, p_r);
        state_nxt = S_RYM;
      end
      S_RYM: if (ustat.done) begin
        if (tgt_acc_r) begin
          ax_nxt = rx_r; ay_nxt = ry_val; ainf_nxt = 1'b0;
          state_nxt = S_RDBL;
        end else begin
          px_nxt = rx_r; py_nxt = ry_val; pinf_nxt = 1'b0;
          k_nxt  = k_r >> 1;
          state_nxt = S_BIT;
        end
      end
      S_OUT: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      issued_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      issued_r <= issued_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    k_r       <= k_nxt;
    p_r       <= p_nxt;
    ca_r      <= ca_nxt;
    px_r      <= px_nxt;
    py_r      <= py_nxt;
    pinf_r    <= pinf_nxt;
    ax_r      <= ax_nxt;
    ay_r      <= ay_nxt;
    ainf_r    <= ainf_nxt;
    ux_r      <= ux_nxt;
    uy_r      <= uy_nxt;
    vx_r      <= vx_nxt;
    dbl_r     <= dbl_nxt;
    tgt_acc_r <= tgt_acc_nxt;
    num_r     <= num_nxt;
    t_r       <= t_nxt;
    lam_r     <= lam_nxt;
    rx_r      <= rx_nxt;
    r0_r      <= r0_nxt;
    r1_r      <= r1_nxt;
    s0_r      <= s0_nxt;
    s1_r      <= s1_nxt;
    q_r       <= q_nxt;
  end

  // result strobe
  assign busy                = (state_r != S_IDLE);
  assign out_valid           = (state_r == S_OUT);
  assign out_result_infinite = ainf_r;
  assign out_result_x        = ainf_r ? '0 : ax_r;
  assign out_result_y        = ainf_r ? '0 : ay_r;

endmodule
`default_nettype wire
